// ----- hdl/midpoint_triangulate_with_check_macros.svh -----
// assertion macros for the midpoint triangulation block
// expects signals named clock and reset in the using module
`ifndef MIDPOINT_TRIANGULATE_WITH_CHECK_MACROS_SVH
`define MIDPOINT_TRIANGULATE_WITH_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define MT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define MT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MT_ASSERT_IMP(lbl, ante, cons)
`define MT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/mt_pkg.sv -----
// shared widths, register codes, beat types and divider step function
// used by every module of the midpoint triangulation block
package mt_pkg;
   localparam int IN_W      = 20;
   localparam int CR_W      = 21;
   localparam int CFG_W     = 63;
   localparam int THR_W     = 19;
   localparam int IDX_W     = 3;
   localparam int F_W       = 24;
   localparam int A_W       = 26;
   localparam int C_W       = 30;
   localparam int D_W       = 32;
   localparam int B_W       = 28;
   localparam int DET_W     = 56;
   localparam int DIV_W     = 56;
   localparam int LMAG_W    = 38;
   localparam int L_W       = 40;
   localparam int LAM_STEPS = 38;
   localparam int LAM_INT   = 22;
   localparam int FRAC      = 16;
   localparam int PT_W      = 32;
   localparam int Q_W       = 40;
   localparam int RPJ_STEPS = 25;
   localparam int U_W       = 27;
   localparam int E_W       = 26;
   localparam int ESQ_W     = 50;

   localparam logic [IDX_W-1:0] REG_ROT0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROT1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROT2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_TRN  = 3'd3;
   localparam logic [IDX_W-1:0] REG_THR  = 3'd4;

   typedef logic signed [IN_W-1:0] coord_type;

   typedef struct packed {
      coord_type p1x;
      coord_type p1y;
      coord_type p2x;
      coord_type p2y;
   } obs_type;

   typedef struct packed {
      logic [2:0][2:0][CR_W-1:0] rot;
      logic [2:0][CR_W-1:0]      trn;
      logic [THR_W-1:0]          thr;
   } cfg_type;

   typedef struct packed {
      obs_type               obs;
      logic [2:0][F_W-1:0]   f2;
      logic [DET_W-1:0]      det;
      logic [DET_W-1:0]      num0;
      logic [DET_W-1:0]      num1;
   } sys_type;

   typedef struct packed {
      obs_type               obs;
      logic [2:0][F_W-1:0]   f2;
      logic [L_W-1:0]        l0;
      logic [L_W-1:0]        l1;
      logic                  det_zero;
   } lam_type;

   typedef struct packed {
      obs_type               obs;
      logic [2:0][PT_W-1:0]  pt;
      logic [2:0][Q_W-1:0]   q;
   } pnt_type;

   // magnitude of a signed word
   function automatic logic [DIV_W-1:0] mag(input logic signed [DIV_W-1:0] v);
      return v[DIV_W-1] ? $unsigned(-v) : $unsigned(v);
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                               input logic [DIV_W-1:0] den,
                                               input logic nb);
      logic [DIV_W:0] sh;
      logic [DIV_W:0] df;
      sh = {rem, nb};
      df = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         return {1'b1, df[DIV_W-1:0]};
      end
      return {1'b0, sh[DIV_W-1:0]};
   endfunction
endpackage

// ----- hdl/mt_front.sv -----
// front end: rotated ray, normal-equation terms, determinant and numerators
// depends on mt_pkg
module mt_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  mt_pkg::cfg_type cfg,
   input  logic            in_valid,
   input  mt_pkg::obs_type in_data,
   output logic            out_valid,
   output mt_pkg::sys_type out_data
);
   localparam int SF_W  = 44;
   localparam int SA_W  = 42;
   localparam int SC_W  = 47;
   localparam int SD_W  = 50;
   localparam int SB0_W = 44;
   localparam int SB1_W = 48;
   localparam int SP_W  = 61;

   logic v1_ff, v2_ff, v3_ff;
   mt_pkg::obs_type obs1_ff, obs2_ff;
   logic [2:0][mt_pkg::F_W-1:0] f2_in, f2_ff, f2b_ff;
   logic signed [SF_W-1:0] fs [3];

   logic signed [SA_W-1:0]  a_s;
   logic signed [SC_W-1:0]  c_s;
   logic signed [SD_W-1:0]  d_s;
   logic signed [SB0_W-1:0] b0_s;
   logic signed [SB1_W-1:0] b1_s;
   logic signed [mt_pkg::F_W-1:0] fx, fy, fz;
   logic signed [mt_pkg::A_W-1:0] a_in, a_ff;
   logic signed [mt_pkg::C_W-1:0] c_in, c_ff;
   logic signed [mt_pkg::D_W-1:0] d_in, d_ff;
   logic signed [mt_pkg::B_W-1:0] b0_in, b0_ff, b1_in, b1_ff;
   logic signed [SP_W-1:0] det_w, n0_w, n1_w;
   mt_pkg::sys_type out_in, out_ff;

   // rotated reference ray
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fs[i] = $signed(cfg.rot[i][0]) * in_data.p1x
               + $signed(cfg.rot[i][1]) * in_data.p1y
               + ($signed(cfg.rot[i][2]) <<< 16);
         f2_in[i] = mt_pkg::F_W'((fs[i] + SF_W'(1 <<< 18)) >>> 19);
      end
   end

   // dot products
   always_comb begin
      fx = $signed(f2_ff[0]);
      fy = $signed(f2_ff[1]);
      fz = $signed(f2_ff[2]);
      a_s  = obs1_ff.p2x * obs1_ff.p2x + obs1_ff.p2y * obs1_ff.p2y + (SA_W'(1) <<< 32);
      c_s  = obs1_ff.p2x * fx + obs1_ff.p2y * fy + (SC_W'(fz) <<< 16);
      d_s  = fx * fx + fy * fy + fz * fz;
      b0_s = $signed(cfg.trn[0]) * obs1_ff.p2x + $signed(cfg.trn[1]) * obs1_ff.p2y
           + (SB0_W'($signed(cfg.trn[2])) <<< 16);
      b1_s = $signed(cfg.trn[0]) * fx + $signed(cfg.trn[1]) * fy + $signed(cfg.trn[2]) * fz;
      a_in  = mt_pkg::A_W'((a_s + SA_W'(1 <<< 15)) >>> 16);
      c_in  = mt_pkg::C_W'((c_s + SC_W'(1 <<< 15)) >>> 16);
      d_in  = mt_pkg::D_W'((d_s + SD_W'(1 <<< 15)) >>> 16);
      b0_in = mt_pkg::B_W'((b0_s + SB0_W'(1 <<< 18)) >>> 19);
      b1_in = mt_pkg::B_W'((b1_s + SB1_W'(1 <<< 18)) >>> 19);
   end

   // determinant and cramer numerators
   always_comb begin
      det_w = c_ff * c_ff - a_ff * d_ff;
      n0_w  = c_ff * b1_ff - d_ff * b0_ff;
      n1_w  = a_ff * b1_ff - c_ff * b0_ff;
      out_in.obs  = obs2_ff;
      out_in.f2   = f2b_ff;
      out_in.det  = mt_pkg::DET_W'(det_w);
      out_in.num0 = mt_pkg::DET_W'(n0_w);
      out_in.num1 = mt_pkg::DET_W'(n1_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         obs1_ff <= in_data;
         f2_ff   <= f2_in;
         obs2_ff <= obs1_ff;
         f2b_ff  <= f2_ff;
         a_ff    <= a_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         b0_ff   <= b0_in;
         b1_ff   <= b1_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;
endmodule

// ----- hdl/mt_lambda.sv -----
// ray scale solver: two lockstep bit-serial restoring dividers, one bit a stage
// depends on mt_pkg
module mt_lambda (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  mt_pkg::sys_type in_data,
   output logic            out_valid,
   output mt_pkg::lam_type out_data
);
   typedef struct packed {
      mt_pkg::obs_type                 obs;
      logic [2:0][mt_pkg::F_W-1:0]     f2;
      logic                            dz;
      logic [mt_pkg::DIV_W-1:0]        ud;
      logic [mt_pkg::DIV_W-1:0]        un0;
      logic [mt_pkg::DIV_W-1:0]        un1;
      logic [mt_pkg::DIV_W-1:0]        rem0;
      logic [mt_pkg::DIV_W-1:0]        rem1;
      logic [mt_pkg::LMAG_W-1:0]       q0;
      logic [mt_pkg::LMAG_W-1:0]       q1;
      logic                            sat0;
      logic                            sat1;
      logic                            neg0;
      logic                            neg1;
   } ldiv_type;

   logic     v_ff  [mt_pkg::LAM_STEPS+1];
   ldiv_type st_in [mt_pkg::LAM_STEPS+1];
   ldiv_type st_ff [mt_pkg::LAM_STEPS+1];
   logic     vo_ff;
   mt_pkg::lam_type out_in, out_ff;
   logic [mt_pkg::L_W-1:0] m0, m1;

   // signs, magnitudes and overflow check
   always_comb begin
      st_in[0].obs  = in_data.obs;
      st_in[0].f2   = in_data.f2;
      st_in[0].dz   = (in_data.det == '0);
      st_in[0].ud   = mt_pkg::mag($signed(in_data.det));
      st_in[0].un0  = mt_pkg::mag($signed(in_data.num0));
      st_in[0].un1  = mt_pkg::mag($signed(in_data.num1));
      st_in[0].rem0 = st_in[0].un0 >> mt_pkg::LAM_INT;
      st_in[0].rem1 = st_in[0].un1 >> mt_pkg::LAM_INT;
      st_in[0].sat0 = st_in[0].rem0 >= st_in[0].ud;
      st_in[0].sat1 = st_in[0].rem1 >= st_in[0].ud;
      st_in[0].neg0 = in_data.num0[mt_pkg::DET_W-1] ^ in_data.det[mt_pkg::DET_W-1];
      st_in[0].neg1 = in_data.num1[mt_pkg::DET_W-1] ^ in_data.det[mt_pkg::DET_W-1];
      st_in[0].q0   = '0;
      st_in[0].q1   = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar s = 1; s <= mt_pkg::LAM_STEPS; s++) begin : g_step
      localparam int K = mt_pkg::LAM_STEPS - s;
      logic nb0, nb1;
      logic [mt_pkg::DIV_W:0] r0, r1;
      // numerator is the scaled magnitude, low fraction bits are zero
      if (K >= mt_pkg::FRAC) begin : g_bit
         assign nb0 = st_ff[s-1].un0[K-mt_pkg::FRAC];
         assign nb1 = st_ff[s-1].un1[K-mt_pkg::FRAC];
      end else begin : g_zero
         assign nb0 = 1'b0;
         assign nb1 = 1'b0;
      end
      always_comb begin
         r0 = mt_pkg::div_step(st_ff[s-1].rem0, st_ff[s-1].ud, nb0);
         r1 = mt_pkg::div_step(st_ff[s-1].rem1, st_ff[s-1].ud, nb1);
         st_in[s] = st_ff[s-1];
         st_in[s].rem0 = r0[mt_pkg::DIV_W-1:0];
         st_in[s].rem1 = r1[mt_pkg::DIV_W-1:0];
         st_in[s].q0 = {st_ff[s-1].q0[mt_pkg::LMAG_W-2:0], r0[mt_pkg::DIV_W]};
         st_in[s].q1 = {st_ff[s-1].q1[mt_pkg::LMAG_W-2:0], r1[mt_pkg::DIV_W]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // saturate and apply sign
   always_comb begin
      m0 = mt_pkg::L_W'(st_ff[mt_pkg::LAM_STEPS].sat0 ? {mt_pkg::LMAG_W{1'b1}}
                                                      : st_ff[mt_pkg::LAM_STEPS].q0);
      m1 = mt_pkg::L_W'(st_ff[mt_pkg::LAM_STEPS].sat1 ? {mt_pkg::LMAG_W{1'b1}}
                                                      : st_ff[mt_pkg::LAM_STEPS].q1);
      out_in.obs      = st_ff[mt_pkg::LAM_STEPS].obs;
      out_in.f2       = st_ff[mt_pkg::LAM_STEPS].f2;
      out_in.det_zero = st_ff[mt_pkg::LAM_STEPS].dz;
      out_in.l0       = st_ff[mt_pkg::LAM_STEPS].neg0 ? ('0 - m0) : m0;
      out_in.l1       = st_ff[mt_pkg::LAM_STEPS].neg1 ? ('0 - m1) : m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= mt_pkg::LAM_STEPS; i++) begin
            v_ff[i] <= 1'b0;
         end
         vo_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= mt_pkg::LAM_STEPS; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         vo_ff <= v_ff[mt_pkg::LAM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_data  = out_ff;
endmodule

// ----- hdl/mt_point.sv -----
// midpoint of the two closest points and its reference-view position
// depends on mt_pkg
module mt_point (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  mt_pkg::cfg_type cfg,
   input  logic            in_valid,
   input  mt_pkg::lam_type in_data,
   output logic            out_valid,
   output mt_pkg::pnt_type out_data
);
   localparam int PS_W = 67;
   localparam int DV_W = 36;
   localparam int QS_W = 60;
   localparam logic signed [PS_W-1:0] PT_MAX = PS_W'(2147483647);
   localparam logic signed [PS_W-1:0] PT_MIN = -PT_MAX - PS_W'(1);

   logic signed [PS_W-1:0] ps [3];
   logic signed [PS_W-1:0] pr [3];
   logic signed [mt_pkg::IN_W-1:0] p2 [2];
   logic signed [DV_W-1:0] dv [3];
   logic signed [QS_W-1:0] qs [3];
   logic [2:0][mt_pkg::PT_W-1:0] pt_in, pt_ff;
   logic [2:0][mt_pkg::Q_W-1:0] q_in;
   mt_pkg::obs_type obs1_ff;
   mt_pkg::pnt_type out_in, out_ff;
   logic v1_ff, v2_ff;

   // sum of scaled rays plus translation, halved and saturated; zero when the determinant is zero
   always_comb begin
      p2[0] = in_data.obs.p2x;
      p2[1] = in_data.obs.p2y;
      for (int i = 0; i < 3; i++) begin
         if (i < 2) begin
            ps[i] = $signed(in_data.l0) * p2[i];
         end else begin
            ps[i] = PS_W'($signed(in_data.l0)) <<< 16;
         end
         ps[i] = ps[i] + $signed(in_data.l1) * $signed(in_data.f2[i])
               + (PS_W'($signed(cfg.trn[i])) <<< 13) + PS_W'(1 <<< 16);
         pr[i] = ps[i] >>> 17;
         if (in_data.det_zero) begin
            pt_in[i] = '0;
         end else if (pr[i] > PT_MAX) begin
            pt_in[i] = mt_pkg::PT_W'(PT_MAX);
         end else if (pr[i] < PT_MIN) begin
            pt_in[i] = mt_pkg::PT_W'(PT_MIN);
         end else begin
            pt_in[i] = mt_pkg::PT_W'(pr[i]);
         end
      end
   end

   // transpose rotation back into the reference view
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dv[j] = (DV_W'($signed(pt_ff[j])) <<< 3) - DV_W'($signed(cfg.trn[j]));
      end
      for (int i = 0; i < 3; i++) begin
         qs[i] = $signed(cfg.rot[0][i]) * dv[0] + $signed(cfg.rot[1][i]) * dv[1]
               + $signed(cfg.rot[2][i]) * dv[2];
         q_in[i] = mt_pkg::Q_W'((qs[i] + QS_W'(1 <<< 21)) >>> 22);
      end
      out_in.obs = obs1_ff;
      out_in.pt  = pt_ff;
      out_in.q   = q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff   <= pt_in;
         obs1_ff <= in_data.obs;
         out_ff  <= out_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = out_ff;
endmodule

// ----- hdl/mt_reproj.sv -----
// reprojection into both views: four lockstep dividers, error clamp and threshold test
// depends on mt_pkg
module mt_reproj (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [mt_pkg::THR_W-1:0]    thr,
   input  logic                        in_valid,
   input  mt_pkg::pnt_type             in_data,
   output logic                        out_valid,
   output logic [2:0][mt_pkg::PT_W-1:0] out_point,
   output logic                        out_inlier,
   output logic                        out_degen
);
   localparam int SUM_W = mt_pkg::ESQ_W + 1;
   localparam int EX_W  = mt_pkg::U_W + 1;

   typedef struct packed {
      mt_pkg::obs_type                          obs;
      logic [2:0][mt_pkg::PT_W-1:0]             pt;
      logic                                     degen;
      logic [3:0][mt_pkg::DIV_W-1:0]            num;
      logic [3:0][mt_pkg::DIV_W-1:0]            den;
      logic [3:0][mt_pkg::DIV_W-1:0]            rem;
      logic [3:0][mt_pkg::RPJ_STEPS-1:0]        q;
      logic [3:0]                               sat;
      logic [3:0]                               neg;
   } rdiv_type;

   logic     v_ff  [mt_pkg::RPJ_STEPS+1];
   rdiv_type st_in [mt_pkg::RPJ_STEPS+1];
   rdiv_type st_ff [mt_pkg::RPJ_STEPS+1];
   logic signed [mt_pkg::DIV_W-1:0] xs [4];
   logic signed [mt_pkg::DIV_W-1:0] zs [4];
   logic signed [mt_pkg::IN_W-1:0]  ob [4];
   logic [mt_pkg::U_W-2:0]          um [4];
   logic signed [mt_pkg::U_W-1:0]   us [4];
   logic signed [EX_W-1:0]          ex [4];
   logic signed [mt_pkg::E_W-1:0]   ec [4];
   logic [3:0][mt_pkg::ESQ_W-1:0]   esq_in, esq_ff;
   logic [2:0][mt_pkg::PT_W-1:0]    pte_ff, pto_ff;
   logic ve_ff, vo_ff, dge_ff, dgo_ff, inl_ff;
   logic [SUM_W-1:0] e_cur, e_ref, thr2;

   // lanes: point x and y over point z, reference x and y over reference z
   always_comb begin
      xs[0] = mt_pkg::DIV_W'($signed(in_data.pt[0]));
      xs[1] = mt_pkg::DIV_W'($signed(in_data.pt[1]));
      xs[2] = mt_pkg::DIV_W'($signed(in_data.q[0]));
      xs[3] = mt_pkg::DIV_W'($signed(in_data.q[1]));
      zs[0] = mt_pkg::DIV_W'($signed(in_data.pt[2]));
      zs[1] = zs[0];
      zs[2] = mt_pkg::DIV_W'($signed(in_data.q[2]));
      zs[3] = zs[2];
      st_in[0].obs   = in_data.obs;
      st_in[0].pt    = in_data.pt;
      st_in[0].degen = (in_data.pt[2] == '0) || (in_data.q[2] == '0);
      for (int l = 0; l < 4; l++) begin
         st_in[0].num[l] = mt_pkg::mag(xs[l]) << mt_pkg::FRAC;
         st_in[0].den[l] = mt_pkg::mag(zs[l]);
         st_in[0].rem[l] = st_in[0].num[l] >> mt_pkg::RPJ_STEPS;
         st_in[0].sat[l] = st_in[0].rem[l] >= st_in[0].den[l];
         st_in[0].neg[l] = xs[l][mt_pkg::DIV_W-1] ^ zs[l][mt_pkg::DIV_W-1];
         st_in[0].q[l]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar s = 1; s <= mt_pkg::RPJ_STEPS; s++) begin : g_step
      localparam int K = mt_pkg::RPJ_STEPS - s;
      logic [mt_pkg::DIV_W:0] r [4];
      always_comb begin
         st_in[s] = st_ff[s-1];
         for (int l = 0; l < 4; l++) begin
            r[l] = mt_pkg::div_step(st_ff[s-1].rem[l], st_ff[s-1].den[l],
                                    st_ff[s-1].num[l][K]);
            st_in[s].rem[l] = r[l][mt_pkg::DIV_W-1:0];
            st_in[s].q[l] = {st_ff[s-1].q[l][mt_pkg::RPJ_STEPS-2:0], r[l][mt_pkg::DIV_W]};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // signed projection, clamped error, square
   always_comb begin
      ob[0] = st_ff[mt_pkg::RPJ_STEPS].obs.p2x;
      ob[1] = st_ff[mt_pkg::RPJ_STEPS].obs.p2y;
      ob[2] = st_ff[mt_pkg::RPJ_STEPS].obs.p1x;
      ob[3] = st_ff[mt_pkg::RPJ_STEPS].obs.p1y;
      for (int l = 0; l < 4; l++) begin
         um[l] = st_ff[mt_pkg::RPJ_STEPS].sat[l] ? (mt_pkg::U_W-1)'(1 << mt_pkg::RPJ_STEPS)
                                                 : {1'b0, st_ff[mt_pkg::RPJ_STEPS].q[l]};
         us[l] = st_ff[mt_pkg::RPJ_STEPS].neg[l] ? -$signed({1'b0, um[l]})
                                                 : $signed({1'b0, um[l]});
         ex[l] = EX_W'(ob[l]) - EX_W'(us[l]);
         if (ex[l] > EX_W'(1 <<< 24)) begin
            ec[l] = mt_pkg::E_W'(1 <<< 24);
         end else if (ex[l] < -EX_W'(1 <<< 24)) begin
            ec[l] = -mt_pkg::E_W'(1 <<< 24);
         end else begin
            ec[l] = mt_pkg::E_W'(ex[l]);
         end
         // square at full width
         esq_in[l] = mt_pkg::ESQ_W'($unsigned(mt_pkg::ESQ_W'(ec[l]) * mt_pkg::ESQ_W'(ec[l])));
      end
   end

   always_comb begin
      e_cur = SUM_W'(esq_ff[0]) + SUM_W'(esq_ff[1]);
      e_ref = SUM_W'(esq_ff[2]) + SUM_W'(esq_ff[3]);
      thr2  = SUM_W'(thr) * SUM_W'(thr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= mt_pkg::RPJ_STEPS; i++) begin
            v_ff[i] <= 1'b0;
         end
         ve_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= mt_pkg::RPJ_STEPS; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         ve_ff <= v_ff[mt_pkg::RPJ_STEPS];
         vo_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         esq_ff <= esq_in;
         pte_ff <= st_ff[mt_pkg::RPJ_STEPS].pt;
         dge_ff <= st_ff[mt_pkg::RPJ_STEPS].degen;
         pto_ff <= pte_ff;
         dgo_ff <= dge_ff;
         inl_ff <= !dge_ff && (e_cur <= thr2) && (e_ref <= thr2);
      end
   end

   assign out_valid  = vo_ff;
   assign out_point  = pto_ff;
   assign out_inlier = inl_ff;
   assign out_degen  = dgo_ff;
endmodule

// ----- hdl/midpoint_triangulate_with_check.sv -----
// midpoint triangulation with reprojection check, fully pipelined
// a req beat runs through the front, ray-scale, midpoint and reprojection sections to its rsp beat
// one beat per cycle sustained; the ray-scale divider (38 one-bit restoring stages) and
// the reprojection divider (25 stages) set the depth; the whole pipe holds while an
// rsp beat waits
// synchronous reset clears all valid bits, loads identity rotation, zero translation, 2.0
`include "midpoint_triangulate_with_check_macros.svh"
module midpoint_triangulate_with_check (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [mt_pkg::IN_W-1:0]  req_ref_x,
   input  logic signed [mt_pkg::IN_W-1:0]  req_ref_y,
   input  logic signed [mt_pkg::IN_W-1:0]  req_cur_x,
   input  logic signed [mt_pkg::IN_W-1:0]  req_cur_y,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [mt_pkg::PT_W-1:0]  rsp_point_x,
   output logic signed [mt_pkg::PT_W-1:0]  rsp_point_y,
   output logic signed [mt_pkg::PT_W-1:0]  rsp_point_z,
   output logic                            rsp_is_inlier,
   output logic                            rsp_degenerate,
   // configuration writes
   input  logic                            csr_we,
   input  logic [mt_pkg::IDX_W-1:0]        csr_index,
   input  logic [mt_pkg::CFG_W-1:0]        csr_wdata
);
   // pose and threshold registers
   logic [mt_pkg::CFG_W-1:0] rot0_ff, rot1_ff, rot2_ff, trn_ff;
   logic [mt_pkg::THR_W-1:0] thr_ff;
   mt_pkg::cfg_type cfg;
   mt_pkg::obs_type obs;
   mt_pkg::sys_type sys;
   mt_pkg::lam_type lam;
   mt_pkg::pnt_type pnt;
   logic sys_valid, lam_valid, pnt_valid;
   logic [2:0][mt_pkg::PT_W-1:0] point;
   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff <= mt_pkg::CFG_W'(1) << 19;
         rot1_ff <= mt_pkg::CFG_W'(1) << 40;
         rot2_ff <= mt_pkg::CFG_W'(1) << 61;
         trn_ff  <= '0;
         thr_ff  <= mt_pkg::THR_W'(1) << 17;
      end else if (csr_we) begin
         unique case (csr_index)
            mt_pkg::REG_ROT0: rot0_ff <= csr_wdata;
            mt_pkg::REG_ROT1: rot1_ff <= csr_wdata;
            mt_pkg::REG_ROT2: rot2_ff <= csr_wdata;
            mt_pkg::REG_TRN:  trn_ff  <= csr_wdata;
            mt_pkg::REG_THR:  thr_ff  <= csr_wdata[mt_pkg::THR_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // unpack 21-bit entries, entry 0 lowest
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cfg.rot[0][j] = rot0_ff[j*mt_pkg::CR_W +: mt_pkg::CR_W];
         cfg.rot[1][j] = rot1_ff[j*mt_pkg::CR_W +: mt_pkg::CR_W];
         cfg.rot[2][j] = rot2_ff[j*mt_pkg::CR_W +: mt_pkg::CR_W];
         cfg.trn[j]    = trn_ff[j*mt_pkg::CR_W +: mt_pkg::CR_W];
      end
      cfg.thr = thr_ff;
      obs.p1x = req_ref_x;
      obs.p1y = req_ref_y;
      obs.p2x = req_cur_x;
      obs.p2y = req_cur_y;
   end

   // one shared advance for every stage; the output stage is the result register
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // rotated ray, 2x2 system, determinant
   mt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_data   (obs),
      .out_valid (sys_valid),
      .out_data  (sys)
   );

   // ray scales by cramer's rule
   mt_lambda u_lambda (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sys_valid),
      .in_data   (sys),
      .out_valid (lam_valid),
      .out_data  (lam)
   );

   // midpoint and its reference-view coordinates
   mt_point u_point (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (lam_valid),
      .in_data   (lam),
      .out_valid (pnt_valid),
      .out_data  (pnt)
   );

   // projections, squared errors, inlier decision
   mt_reproj u_reproj (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .thr        (thr_ff),
      .in_valid   (pnt_valid),
      .in_data    (pnt),
      .out_valid  (rsp_valid),
      .out_point  (point),
      .out_inlier (rsp_is_inlier),
      .out_degen  (rsp_degenerate)
   );

   assign rsp_point_x = $signed(point[0]);
   assign rsp_point_y = $signed(point[1]);
   assign rsp_point_z = $signed(point[2]);

   // a degenerate point is never an inlier
   `MT_ASSERT_IMP(a_inlier_not_degen, rsp_valid && rsp_is_inlier, !rsp_degenerate)
   // zero depth of the returned point always flags degenerate
   `MT_ASSERT_IMP(a_zero_depth_degen, rsp_valid && (rsp_point_z == '0), rsp_degenerate)
   // a waiting result beat holds the whole pipe
   `MT_ASSERT_IMP(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)
endmodule
